/* src/plrc_pkg.sv */
// Package for the piecewise-linear range calibration: widths, stage map, types, divider step.
`default_nettype none

package plrc_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned DistW     = 10;
  localparam int unsigned FacW      = 16;
  localparam int unsigned CountW    = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumPoints = 3;
  localparam int unsigned ProdW     = SampleW + FacW;
  localparam int unsigned NumW      = FacW + DistW;

  localparam int unsigned FactorFracBitsDefault = 14;
  localparam logic [FacW-1:0] FactorReset = FacW'(16384);

  // Restoring divider: one quotient bit per step, a few steps per register stage.
  localparam int unsigned DivSteps        = FacW;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = DivSteps / DivBitsPerStage;

  // Pipeline stage map.
  localparam int unsigned StSel     = 0;
  localparam int unsigned StMul     = 1;
  localparam int unsigned StDiv0    = 2;
  localparam int unsigned StFac     = StDiv0 + DivStages;
  localparam int unsigned StProd    = StFac + 1;
  localparam int unsigned StOut     = StProd + 1;
  localparam int unsigned NumStages = StOut + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_POINT0_DIST = 3'd1,
    CFG_POINT1_DIST = 3'd2,
    CFG_POINT2_DIST = 3'd3,
    CFG_POINT0_FAC  = 3'd4,
    CFG_POINT1_FAC  = 3'd5,
    CFG_POINT2_FAC  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] cm;
    logic               pass;
    logic               interp;
    logic [FacW-1:0]    fl;
    logic               neg;
    logic [FacW-1:0]    dmag;
    logic [DistW-1:0]   off;
    logic [DistW-1:0]   gap;
  } sel_t;

  typedef struct packed {
    logic [SampleW-1:0] cm;
    logic               pass;
    logic               interp;
    logic [FacW-1:0]    fl;
    logic               neg;
    logic [DistW-1:0]   gap;
    logic [DistW-1:0]   rem;
    logic [FacW-1:0]    nlo;
    logic [FacW-1:0]    quot;
  } div_t;

  typedef struct packed {
    logic [SampleW-1:0] cm;
    logic               pass;
    logic [FacW-1:0]    fac;
  } fac_t;

  typedef struct packed {
    logic [SampleW-1:0] cm;
    logic               pass;
    logic [ProdW-1:0]   prod;
  } prod_t;

  typedef struct packed {
    logic [SampleW-1:0] corrected;
    logic               sat;
    logic               pass;
  } out_t;

  // One restoring-division step: bring in the next numerator bit, subtract if it fits.
  function automatic div_t div_step(div_t x);
    logic [DistW:0] t;
    logic           qb;
    div_t           y;
    y = x;
    t = {x.rem, x.nlo[FacW-1]};
    if (t >= {1'b0, x.gap}) begin
      y.rem = DistW'(t - {1'b0, x.gap});
      qb    = 1'b1;
    end else begin
      y.rem = t[DistW-1:0];
      qb    = 1'b0;
    end
    y.nlo  = {x.nlo[FacW-2:0], 1'b0};
    y.quot = {x.quot[FacW-2:0], qb};
    return y;
  endfunction

endpackage

`default_nettype wire

/* src/piecewise_linear_range_calibration.sv */
// Top level: calibration registers and the sample correction pipeline.
// Items pass the selection, multiply, divider, factor, product and output registers in order.
// Throughput: one item per cycle unless stalled; interpolation divider: 8 stages of 2 quotient bits.
// Each stage holds its item under stall and loads as soon as the stage after it frees up.
// Reset clears all valid bits and sets point count 0, distances 0, factors 1.0 at 14 fraction bits.
`default_nettype none

module piecewise_linear_range_calibration #(
  parameter int unsigned FACTOR_FRAC_BITS = plrc_pkg::FactorFracBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plrc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [plrc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [plrc_pkg::SampleW-1:0]    raw_distance_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [plrc_pkg::SampleW-1:0]    corrected_distance_o,
  output logic                            saturated_o
);
  import plrc_pkg::*;

  // ---------------- calibration registers ----------------
  logic [CountW-1:0] count_q;
  logic [DistW-1:0]  pt_dist_q [NumPoints];
  logic [FacW-1:0]   pt_fac_q  [NumPoints];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NumPoints; i++) begin
        pt_dist_q[i] <= '0;
        pt_fac_q[i]  <= FactorReset;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POINT_COUNT: count_q      <= cfg_data_i[CountW-1:0];
        CFG_POINT0_DIST: pt_dist_q[0] <= cfg_data_i[DistW-1:0];
        CFG_POINT1_DIST: pt_dist_q[1] <= cfg_data_i[DistW-1:0];
        CFG_POINT2_DIST: pt_dist_q[2] <= cfg_data_i[DistW-1:0];
        CFG_POINT0_FAC:  pt_fac_q[0]  <= cfg_data_i[FacW-1:0];
        CFG_POINT1_FAC:  pt_fac_q[1]  <= cfg_data_i[FacW-1:0];
        CFG_POINT2_FAC:  pt_fac_q[2]  <= cfg_data_i[FacW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   rdy;

  always_comb begin
    rdy[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------- stage: point selection ----------------
  sel_t sel_d, sel_q;

  always_comb begin
    logic [DistW-1:0] last_d;
    logic [FacW-1:0]  last_f;
    logic [DistW-1:0] dl, dh;
    logic [FacW-1:0]  fl, fh;
    logic             up1;

    last_d = (count_q == CountW'(2)) ? pt_dist_q[1] : pt_dist_q[2];
    last_f = (count_q == CountW'(2)) ? pt_fac_q[1]  : pt_fac_q[2];
    up1    = raw_distance_i <= SampleW'(pt_dist_q[1]);
    dl     = up1 ? pt_dist_q[0] : pt_dist_q[1];
    dh     = up1 ? pt_dist_q[1] : pt_dist_q[2];
    fl     = up1 ? pt_fac_q[0]  : pt_fac_q[1];
    fh     = up1 ? pt_fac_q[1]  : pt_fac_q[2];

    sel_d.cm     = raw_distance_i;
    sel_d.pass   = (count_q == '0);
    sel_d.interp = 1'b0;
    sel_d.fl     = pt_fac_q[0];
    sel_d.neg    = fh < fl;
    sel_d.dmag   = (fh < fl) ? (fl - fh) : (fh - fl);
    // Below the last point the sample fits in the distance width.
    sel_d.off    = raw_distance_i[DistW-1:0] - dl;
    sel_d.gap    = dh - dl;

    priority if (count_q == CountW'(1)) begin
      sel_d.fl = pt_fac_q[0];
    end else if (raw_distance_i <= SampleW'(pt_dist_q[0])) begin
      sel_d.fl = pt_fac_q[0];
    end else if (raw_distance_i >= SampleW'(last_d)) begin
      sel_d.fl = last_f;
    end else begin
      sel_d.fl     = fl;
      sel_d.interp = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StSel]) begin
      sel_q <= sel_d;
    end
  end

  // ---------------- stage: factor delta times offset ----------------
  div_t mul_d, mul_q;

  always_comb begin
    logic [NumW-1:0] num;
    num          = NumW'(sel_q.dmag) * NumW'(sel_q.off);
    mul_d.cm     = sel_q.cm;
    mul_d.pass   = sel_q.pass;
    mul_d.interp = sel_q.interp;
    mul_d.fl     = sel_q.fl;
    mul_d.neg    = sel_q.neg;
    mul_d.gap    = sel_q.gap;
    // For interpolated items the offset never exceeds the gap, so the top bits start below the divisor.
    mul_d.rem    = num[NumW-1:FacW];
    mul_d.nlo    = num[FacW-1:0];
    mul_d.quot   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StMul]) begin
      mul_q <= mul_d;
    end
  end

  // ---------------- stages: divide by the distance gap ----------------
  div_t div_in [DivStages];
  div_t div_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    div_t step_d;

    if (s == 0) begin : g_first
      assign div_in[s] = mul_q;
    end else begin : g_next
      assign div_in[s] = div_q[s-1];
    end

    always_comb begin
      step_d = div_in[s];
      for (int b = 0; b < DivBitsPerStage; b++) begin
        step_d = div_step(step_d);
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[StDiv0 + s]) begin
        div_q[s] <= step_d;
      end
    end
  end

  // ---------------- stage: final factor ----------------
  fac_t fac_d, fac_q;
  div_t div_last;

  assign div_last = div_q[DivStages-1];

  always_comb begin
    fac_d.cm   = div_last.cm;
    fac_d.pass = div_last.pass;
    // Interpolated factor always lies between the two point factors.
    if (!div_last.interp) begin
      fac_d.fac = div_last.fl;
    end else if (div_last.neg) begin
      fac_d.fac = div_last.fl - div_last.quot;
    end else begin
      fac_d.fac = div_last.fl + div_last.quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StFac]) begin
      fac_q <= fac_d;
    end
  end

  // ---------------- stage: sample times factor ----------------
  prod_t prod_d, prod_q;

  always_comb begin
    prod_d.cm   = fac_q.cm;
    prod_d.pass = fac_q.pass;
    prod_d.prod = ProdW'(fac_q.cm) * ProdW'(fac_q.fac);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StProd]) begin
      prod_q <= prod_d;
    end
  end

  // ---------------- stage: scale and saturate ----------------
  out_t out_d, out_q;

  always_comb begin
    logic [ProdW-1:0] shifted;
    shifted = prod_q.prod >> FACTOR_FRAC_BITS;
    out_d.pass = prod_q.pass;
    if (prod_q.pass) begin
      out_d.corrected = prod_q.cm;
      out_d.sat       = 1'b0;
    end else if (|shifted[ProdW-1:SampleW]) begin
      out_d.corrected = '1;
      out_d.sat       = 1'b1;
    end else begin
      out_d.corrected = shifted[SampleW-1:0];
      out_d.sat       = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o          = valid_q[StOut];
  assign corrected_distance_o = out_q.corrected;
  assign saturated_o          = out_q.sat;

  // ---------------- assertions ----------------
  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> corrected_distance_o == '1)
    else $error("saturated result not clamped");

  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_q.pass |-> !saturated_o)
    else $error("pass-through item flagged saturated");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q) && out_stall_i)
    else $error("input stalled while the pipeline has a free stage");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StFac-1] && div_last.interp |-> div_last.rem < div_last.gap)
    else $error("divider remainder not below the gap");

endmodule

`default_nettype wire

/* verif/piecewise_linear_range_calibration_tb.sv */
// Testbench for the range calibration pipeline: directed and random traffic checked against a local predictor.
module piecewise_linear_range_calibration_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plrc_pkg::*;

  localparam int unsigned FracBits    = FactorFracBitsDefault;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 104;

  typedef struct {
    logic [SampleW-1:0] raw;
    logic [SampleW-1:0] corrected;
    logic               sat;
  } correction_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  raw_distance_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [SampleW-1:0]  corrected_distance_o;
  logic                saturated_o;

  // Local copy of the calibration table.
  logic [CountW-1:0] cal_count = '0;
  logic [DistW-1:0]  cal_dist [NumPoints] = '{default: '0};
  logic [FacW-1:0]   cal_fac  [NumPoints] = '{default: FactorReset};

  logic [SampleW-1:0] pending_samples [$];
  correction_t        expected_corrections [$];
  int unsigned        mismatch_count = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  piecewise_linear_range_calibration uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .raw_distance_i       (raw_distance_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .corrected_distance_o (corrected_distance_o),
    .saturated_o          (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [FacW-1:0] factor_at(logic [SampleW-1:0] cm);
    int unsigned n;
    int unsigned hi;
    longint      dl, dh, fl, fh, pos, f;
    n = cal_count;
    if (n == 1) return cal_fac[0];
    if (cm <= cal_dist[0]) return cal_fac[0];
    if (cm >= cal_dist[n-1]) return cal_fac[n-1];
    hi = 1;
    while (hi < n && cm > cal_dist[hi]) hi++;
    if (hi >= n) return cal_fac[n-1];
    dl  = cal_dist[hi-1];
    dh  = cal_dist[hi];
    fl  = cal_fac[hi-1];
    fh  = cal_fac[hi];
    pos = cm;
    if (dh - dl <= 0) return cal_fac[n-1];
    // Signed division truncates toward zero.
    f = fl + ((fh - fl) * (pos - dl)) / (dh - dl);
    if (f < 0) f = 0;
    if (f > 65535) f = 65535;
    return FacW'(f);
  endfunction

  function automatic correction_t correct_sample(logic [SampleW-1:0] cm);
    correction_t      c;
    logic [ProdW-1:0] prod;
    c.raw = cm;
    if (cal_count == 0) begin
      c.corrected = cm;
      c.sat       = 1'b0;
    end else begin
      prod = (ProdW'(cm) * ProdW'(factor_at(cm))) >> FracBits;
      c.sat       = (prod > ProdW'(16'hFFFF));
      c.corrected = c.sat ? 16'hFFFF : prod[SampleW-1:0];
    end
    return c;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 0;
    if (sel < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [SampleW-1:0] draw_sample();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 30) return SampleW'($urandom_range(0, 1023));
    if (sel < 55) begin
      // Land on or next to a breakpoint.
      v = $urandom_range(0, 6);
      v = v + int'(cal_dist[$urandom_range(0, NumPoints-1)]) - 3;
      if (v < 0) v = 0;
      return SampleW'(v);
    end
    if (sel < 70) return SampleW'($urandom_range(0, 65535));
    if (sel < 78) begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'hFFFE;
        default: return 16'hFFFF;
      endcase
    end
    if (sel < 90) return SampleW'($urandom_range(16384, 65535));
    return SampleW'($urandom_range(1024, 8191));
  endfunction

  function automatic logic [DistW-1:0] random_distance();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return '0;
    if (sel < 24) return DistW'(800);
    return DistW'($urandom_range(0, 800));
  endfunction

  function automatic logic [FacW-1:0] random_factor();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 20) return 16'hFFFF;
    if (sel < 40) return FacW'($urandom_range(12000, 21000));
    return FacW'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, logic [SampleW-1:0] raw,
                                 int unsigned got, int unsigned want);
    mismatch_count++;
    $display("mismatch %s: raw %0d got %0d want %0d", what, raw, got, want);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_POINT_COUNT: cal_count   = data[CountW-1:0];
      CFG_POINT0_DIST: cal_dist[0] = data[DistW-1:0];
      CFG_POINT1_DIST: cal_dist[1] = data[DistW-1:0];
      CFG_POINT2_DIST: cal_dist[2] = data[DistW-1:0];
      CFG_POINT0_FAC:  cal_fac[0]  = data[FacW-1:0];
      CFG_POINT1_FAC:  cal_fac[1]  = data[FacW-1:0];
      CFG_POINT2_FAC:  cal_fac[2]  = data[FacW-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits above a register's width carry noise; the block drops them.
  task automatic load_table(logic [CountW-1:0] count,
                            logic [DistW-1:0] d0, logic [DistW-1:0] d1, logic [DistW-1:0] d2,
                            logic [FacW-1:0] f0, logic [FacW-1:0] f1, logic [FacW-1:0] f2);
    write_reg(CFG_POINT_COUNT, {(CfgDataW-CountW)'($urandom), count});
    write_reg(CFG_POINT0_DIST, {(CfgDataW-DistW)'($urandom), d0});
    write_reg(CFG_POINT1_DIST, {(CfgDataW-DistW)'($urandom), d1});
    write_reg(CFG_POINT2_DIST, {(CfgDataW-DistW)'($urandom), d2});
    write_reg(CFG_POINT0_FAC, f0);
    write_reg(CFG_POINT1_FAC, f1);
    write_reg(CFG_POINT2_FAC, f2);
  endtask

  task automatic load_random_table();
    logic [DistW-1:0]  d [NumPoints];
    logic [FacW-1:0]   f [NumPoints];
    logic [DistW-1:0]  t;
    logic [CountW-1:0] count;
    int unsigned       sel;
    for (int k = 0; k < NumPoints; k++) begin
      d[k] = random_distance();
      f[k] = random_factor();
    end
    // Mostly ascending tables; leave some out of order.
    if ($urandom_range(0, 9) < 7) begin
      if (d[0] > d[1]) begin t = d[0]; d[0] = d[1]; d[1] = t; end
      if (d[1] > d[2]) begin t = d[1]; d[1] = d[2]; d[2] = t; end
      if (d[0] > d[1]) begin t = d[0]; d[0] = d[1]; d[1] = t; end
    end
    sel   = $urandom_range(0, 9);
    count = (sel == 0) ? 2'd0 : (sel == 1) ? 2'd1 : (sel < 5) ? 2'd2 : 2'd3;
    load_table(count, d[0], d[1], d[2], f[0], f[1], f[2]);
  endtask

  // Hold until the sender is drained and every result is back, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_corrections.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Sender: bursts of random length with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      raw_distance_i <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_corrections.push_back(correct_sample(raw_distance_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_samples.size() != 0) begin
          in_valid_i     <= 1'b1;
          raw_distance_i <= pending_samples.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= sender_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted item, stall in modes that change now and then.
  always @(posedge clk_i or negedge rst_ni) begin
    correction_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_corrections.size() == 0) begin
          report_mismatch("result with nothing pending", '0, corrected_distance_o, 0);
        end else begin
          want = expected_corrections.pop_front();
          if (corrected_distance_o !== want.corrected)
            report_mismatch("corrected_distance", want.raw, corrected_distance_o,
                            want.corrected);
          if (saturated_o !== want.sat)
            report_mismatch("saturated", want.raw, saturated_o, want.sat);
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 160);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Empty table after reset: samples pass through.
    pending_samples = '{16'd0, 16'hFFFF, 16'd1, 16'hAAAA, 16'h5555};
    wait_idle();

    // One point: its factor everywhere, saturating at the top.
    load_table(2'd1, 10'd300, 10'd0, 10'd0, 16'hFFFF, 16'd0, 16'd0);
    pending_samples = '{16'hFFFF, 16'd4, 16'd300};
    wait_idle();

    // Three ascending points: clamp below and above, interpolate between.
    load_table(2'd3, 10'd100, 10'd400, 10'd800, 16'd8192, 16'd30000, 16'hFFFF);
    pending_samples = '{16'd0, 16'd99, 16'd100, 16'd101, 16'd250, 16'd400, 16'd401,
                        16'd799, 16'd800, 16'd801};
    wait_idle();

    // Two points with a falling factor down to zero.
    load_table(2'd2, 10'd200, 10'd600, 10'd0, 16'd40000, 16'd0, 16'h1234);
    pending_samples = '{16'd200, 16'd300, 16'd599};
    wait_idle();

    // Distances out of order.
    load_table(2'd3, 10'd500, 10'd100, 10'd300, 16'd20000, 16'd9000, 16'd50000);
    pending_samples = '{16'd200, 16'd400, 16'd600};
    wait_idle();

    for (int p = 0; p < RandPhases; p++) begin
      load_random_table();
      for (int i = 0; i < PhaseItems; i++) pending_samples.push_back(draw_sample());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
